// ===== rtl/sprite_rle_row_decoder_core_assert.svh =====
// Assertion macros shared by the sprite row decoder checker.
`ifndef SPRITE_RLE_ROW_DECODER_CORE_ASSERT_SVH
`define SPRITE_RLE_ROW_DECODER_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srd check failed");

// Antecedent implies consequent in the next cycle.
`define SRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srd check failed");

`endif

// ===== rtl/srd_pkg.sv =====
// Types and constants of the sprite run-length row decoder.
package srd_pkg;

  // Control byte fields.
  localparam logic [7:0] SKIP_FLAG  = 8'h80;
  localparam logic [7:0] SKIP_MASK  = 8'h7F;
  localparam logic [7:0] RUN_FLAG   = 8'h40;
  localparam logic [7:0] COUNT_MASK = 8'h3F;

  localparam logic [7:0] WIDTH_RESET = 8'd1;

  // Decoder mode, one-hot.
  typedef enum logic [2:0] {
    MODE_CTRL   = 3'b001,
    MODE_RUNVAL = 3'b010,
    MODE_RAW    = 3'b100
  } srd_mode_t;

  // One input request.
  typedef struct packed {
    logic [7:0] encoded_byte;
    logic       row_start;
  } srd_in_t;

  // One result request.
  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] column;
    logic [7:0] pixel_index;
    logic       last_of_input;
    logic       row_complete;
    logic       byte_ignored;
  } srd_out_t;

  // Classified command from the front to the back: count results starting at column.
  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] column;
    logic [7:0] pixel_index;
    logic [5:0] count;
    logic       row_complete;
    logic       byte_ignored;
  } srd_cmd_t;

endpackage

// ===== rtl/srd_front.sv =====
// Front end: holds the row decode state and turns each byte into one command.
module srd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              accept,
  input  srd_pkg::srd_in_t  in_data,
  output srd_pkg::srd_cmd_t cmd
);

  logic [7:0]         width_r;
  logic [7:0]         col_r, col_nxt;
  srd_pkg::srd_mode_t mode_r, mode_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               fin_r, fin_nxt;

  logic [7:0]         col0;
  srd_pkg::srd_mode_t mode0;
  logic [5:0]         cnt0;
  logic               fin0;
  logic [7:0]         b;
  logic [7:0]         avail;
  logic [5:0]         run_n;
  logic [8:0]         skip_sum;
  logic [7:0]         col1;

  // Frame width register; the user must write it only while the block is idle, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= srd_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  // Classify the byte against the current state.
  always_comb begin
    b    = in_data.encoded_byte;
    col0 = in_data.row_start ? 8'd0 : col_r;
    mode0 = in_data.row_start ? srd_pkg::MODE_CTRL : mode_r;
    cnt0 = in_data.row_start ? 6'd0 : cnt_r;
    fin0 = in_data.row_start ? 1'b0 : fin_r;
    // A column already at the edge closes the row before the byte is used.
    if (!fin0 && (col0 >= width_r)) begin
      fin0  = 1'b1;
      mode0 = srd_pkg::MODE_CTRL;
      cnt0  = 6'd0;
    end

    avail    = width_r - col0;
    run_n    = ({2'b00, cnt0} < avail) ? cnt0 : avail[5:0];
    skip_sum = {1'b0, col0} + {2'b00, b[6:0] & srd_pkg::SKIP_MASK[6:0]};
    col1     = col0;

    col_nxt  = col0;
    mode_nxt = mode0;
    cnt_nxt  = cnt0;
    fin_nxt  = fin0;

    cmd.pixel_valid  = 1'b0;
    cmd.column       = col0;
    cmd.pixel_index  = 8'd0;
    cmd.count        = 6'd1;
    cmd.row_complete = fin0;
    cmd.byte_ignored = 1'b0;

    if (fin0) begin
      cmd.byte_ignored = 1'b1;
    end else begin
      case (mode0)
        srd_pkg::MODE_RUNVAL: begin
          col1     = col0 + {2'b00, run_n};
          mode_nxt = srd_pkg::MODE_CTRL;
          cnt_nxt  = 6'd0;
          if (run_n != 6'd0) begin
            cmd.pixel_valid = 1'b1;
            cmd.pixel_index = b;
            cmd.count       = run_n;
          end else begin
            cmd.column = col1;
          end
        end
        srd_pkg::MODE_RAW: begin
          col1            = col0 + 8'd1;
          cnt_nxt         = cnt0 - 6'd1;
          mode_nxt        = (cnt_nxt == 6'd0) ? srd_pkg::MODE_CTRL : srd_pkg::MODE_RAW;
          cmd.pixel_valid = 1'b1;
          cmd.pixel_index = b;
        end
        default: begin
          if ((b & srd_pkg::SKIP_FLAG) != 8'd0) begin
            col1     = (skip_sum > {1'b0, width_r}) ? width_r : skip_sum[7:0];
            mode_nxt = srd_pkg::MODE_CTRL;
          end else if ((b & srd_pkg::RUN_FLAG) != 8'd0) begin
            mode_nxt = srd_pkg::MODE_RUNVAL;
            cnt_nxt  = b[5:0] & srd_pkg::COUNT_MASK[5:0];
          end else begin
            cnt_nxt  = b[5:0] & srd_pkg::COUNT_MASK[5:0];
            mode_nxt = (cnt_nxt != 6'd0) ? srd_pkg::MODE_RAW : srd_pkg::MODE_CTRL;
          end
          cmd.column = col1;
        end
      endcase
      col_nxt = col1;
      // Reaching the edge completes the row and drops any pending raw bytes.
      if (col1 >= width_r) begin
        fin_nxt  = 1'b1;
        mode_nxt = srd_pkg::MODE_CTRL;
        cnt_nxt  = 6'd0;
      end
      cmd.row_complete = fin_nxt;
    end
  end

  // Decode state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= 8'd0;
      mode_r <= srd_pkg::MODE_CTRL;
      cnt_r  <= 6'd0;
      fin_r  <= 1'b1;
    end else if (accept) begin
      col_r  <= col_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

// ===== rtl/srd_cmd_fifo.sv =====
// Short command queue between the front and the back.
module srd_cmd_fifo #(
  parameter int Depth = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srd_pkg::srd_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output srd_pkg::srd_cmd_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  srd_pkg::srd_cmd_t mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == CntW'(Depth));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/srd_back.sv =====
// Back end: expands each command into results, one per cycle while the output register is free or popped.
module srd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  srd_pkg::srd_cmd_t cmd,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output srd_pkg::srd_out_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  srd_pkg::srd_out_t out_data_r;
  logic [5:0]        beat_r, beat_nxt;
  logic              load;
  logic              last_beat;

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;
  assign load      = cmd_valid && (!out_valid_r || out_pop);
  assign last_beat = (beat_r == (cmd.count - 6'd1));
  assign cmd_pop   = load && last_beat;

  // Next beat and output occupancy.
  always_comb begin
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      beat_nxt      = last_beat ? 6'd0 : beat_r + 6'd1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= 6'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.pixel_valid   <= cmd.pixel_valid;
      out_data_r.column        <= cmd.column + {2'b00, beat_r};
      out_data_r.pixel_index   <= cmd.pixel_index;
      out_data_r.last_of_input <= last_beat;
      out_data_r.row_complete  <= cmd.row_complete;
      out_data_r.byte_ignored  <= cmd.byte_ignored;
    end
  end

endmodule

// ===== rtl/sprite_rle_row_decoder_core.sv =====
// An accepted byte becomes a command in the command queue, which the back end expands into the output register.
// Throughput: one byte per cycle; a run value byte of n pixels occupies the
// back-end expander for n results, and the input stalls once the command queue fills.
// Reset (synchronous, rst_n low): frame width 1, column 0, expecting a control byte,
// row complete until a row start; queue and output register empty.
module sprite_rle_row_decoder_core #(
  parameter int CmdDepth = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_push,
  output logic              in_full,
  input  srd_pkg::srd_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output srd_pkg::srd_out_t out_data
);

  srd_pkg::srd_cmd_t front_cmd;
  srd_pkg::srd_cmd_t head_cmd;
  logic              accept;
  logic              cmd_valid;
  logic              cmd_pop;

  assign accept = in_push && !in_full;

  // Byte classifier and decode state.
  srd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_data   (in_data),
    .cmd       (front_cmd)
  );

  // Command queue.
  srd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (head_cmd)
  );

  // Run expander and output register.
  srd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/srd_checker.sv =====
// Port-level checker for the sprite row decoder, bound to the top level.
`include "sprite_rle_row_decoder_core_assert.svh"

module srd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input srd_pkg::srd_out_t out_data
);

  // A waiting result is not withdrawn before it is taken.
  `SRD_ASSERT_NEXT(a_out_holds, clk, rst_n, !out_empty && !out_pop, !out_empty)

  // A status-only result is always the only result of its byte.
  `SRD_ASSERT_NOW(a_status_last, clk, rst_n, !out_empty && !out_data.pixel_valid, out_data.last_of_input)

  // A status-only result carries a zero palette index.
  `SRD_ASSERT_NOW(a_status_zero, clk, rst_n, !out_empty && !out_data.pixel_valid, out_data.pixel_index == 8'd0)

  // An ignored byte writes nothing and reports a complete row.
  `SRD_ASSERT_NOW(a_ignored, clk, rst_n, !out_empty && out_data.byte_ignored, out_data.row_complete && !out_data.pixel_valid)

endmodule

bind sprite_rle_row_decoder_core srd_checker u_srd_checker (.*);
